/* design/kvls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kvls_pkg
// Shared types and constants of the keyframe vec3 lerp sampler.
// ----------------------------------------------------------------------------
package kvls_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int SEG_W     = 6;
    localparam int CLAMP_W   = 2;
    localparam int KCNT_W    = 7;
    localparam int FRAC_W    = 16;
    localparam int QUOT_W    = FRAC_W + 1;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = DIFF_W + QUOT_W + 1;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CLAMP_W-1:0] CLAMP_NONE  = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_FIRST = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_LAST  = 2'd2;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } t_vec3;

    localparam int VEC_W = $bits(t_vec3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_VAL_L,
        ST_VAL_R,
        ST_DIV,
        ST_LERP,
        ST_KEY,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* design/kvls_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kvls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/kvls_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kvls_div
// Restoring divider for the segment fraction floor(d * 2^16 / len), d <= len.
// One quotient bit per cycle; a zero-length segment gives a zero fraction.
// ----------------------------------------------------------------------------
module kvls_div
    import kvls_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [DATA_W-1:0]    i_dividend,
    input  wire [DATA_W-1:0]    i_divisor,
    output logic                o_busy,
    output logic [QUOT_W-1:0]   o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W-1:0]    r_div;
    logic [QUOT_W-1:0]    r_quot;

    logic              ge;
    logic [DATA_W:0]   rem_sub;

    always_comb begin
        ge      = (r_rem >= {1'b0, r_div}) && (r_div != '0);
        rem_sub = ge ? (r_rem - {1'b0, r_div}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_dividend};
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the shift cannot overflow
            r_rem  <= {rem_sub[DATA_W-1:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

/* design/kvls_lerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kvls_lerp
// Three-component lerp on one shared multiplier: a + floor((b - a) * f / 2^16).
// Components flow through subtract, multiply and add stages, one per cycle.
// ----------------------------------------------------------------------------
module kvls_lerp
    import kvls_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  t_vec3               i_a,
    input  t_vec3               i_b,
    input  wire [QUOT_W-1:0]    i_frac,
    output logic                o_done,
    output t_vec3               o_res
);

    logic              r_issue;
    logic [1:0]        r_cnt;
    logic              r_s1_vld;
    logic [1:0]        r_s1_idx;
    logic [DIFF_W-1:0] r_s1_diff;
    logic [DATA_W-1:0] r_s1_a;
    logic              r_s2_vld;
    logic [1:0]        r_s2_idx;
    logic [PROD_W-1:0] r_s2_prod;
    logic [DATA_W-1:0] r_s2_a;
    logic              r_done;
    t_vec3             r_res;

    logic [DATA_W-1:0] a_c;
    logic [DATA_W-1:0] b_c;
    logic [DATA_W-1:0] sum;

    always_comb begin
        case (r_cnt)
            COMP_X: begin
                a_c = i_a.x;
                b_c = i_b.x;
            end
            COMP_Y: begin
                a_c = i_a.y;
                b_c = i_b.y;
            end
            default: begin
                a_c = i_a.z;
                b_c = i_b.z;
            end
        endcase
    end

    // arithmetic shift of the product is the floor division by 2^16
    assign sum = r_s2_a + r_s2_prod[FRAC_W +: DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_cnt    <= COMP_X;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
                r_cnt   <= COMP_X;
            end else if (r_issue) begin
                if (r_cnt == COMP_Z) begin
                    r_issue <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            r_s1_vld <= r_issue;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld && (r_s2_idx == COMP_Z);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_cnt;
        r_s1_a    <= a_c;
        r_s1_diff <= {b_c[DATA_W-1], b_c} - {a_c[DATA_W-1], a_c};
        r_s2_idx  <= r_s1_idx;
        r_s2_a    <= r_s1_a;
        r_s2_prod <= PROD_W'($signed(r_s1_diff) * $signed({1'b0, i_frac}));
        if (r_s2_vld) begin
            case (r_s2_idx)
                COMP_X:  r_res.x <= sum;
                COMP_Y:  r_res.y <= sum;
                default: r_res.z <= sum;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

/* design/keyframe_vec3_lerp_sampler_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_vec3_lerp_sampler_unit
// Keyframe track of vec3 values with linear-interpolated sampling.
// ----------------------------------------------------------------------------
// Keys live in two RAMs (times, and x/y/z values) with one read port each.
// A key write is taken while idle, and the unit stays idle. A sample takes one
// item at a time. A query at or before the first key, or at or after the
// last key, gives that key. Otherwise the time RAM is scanned one key per
// cycle from key 0 until a segment brackets the query (else the last key is
// given), then the bit-serial fraction divider and the 3-component
// multiply pipeline run. Results wait in an output register, so a new item
// is taken while a result is still pending.
module keyframe_vec3_lerp_sampler_unit
    import kvls_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [KCNT_W-1:0]    i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_req_type,
    input  wire [IDX_W-1:0]     i_key_index,
    input  wire [DATA_W-1:0]    i_key_time,
    input  wire [DATA_W-1:0]    i_key_x,
    input  wire [DATA_W-1:0]    i_key_y,
    input  wire [DATA_W-1:0]    i_key_z,
    input  wire [DATA_W-1:0]    i_query_time,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [DATA_W-1:0]   o_out_x,
    output logic [DATA_W-1:0]   o_out_y,
    output logic [DATA_W-1:0]   o_out_z,
    output logic [SEG_W-1:0]    o_out_segment,
    output logic [CLAMP_W-1:0]  o_out_clamped
);

    t_state              r_state;
    t_state              n_state;
    logic [KCNT_W-1:0]   r_key_count;
    logic [DATA_W-1:0]   r_q;
    logic [DATA_W-1:0]   r_left;
    logic [KEY_AW-1:0]   r_seg;
    t_vec3               r_va;
    t_vec3               r_vb;
    t_vec3               r_res;
    logic [CLAMP_W-1:0]  r_clamp;

    logic                in_xfer;
    logic                key_wr;
    logic [KEY_AW-1:0]   last_idx;
    logic [KEY_AW-1:0]   t_raddr;
    logic [KEY_AW-1:0]   v_raddr;
    logic [DATA_W-1:0]   t_rdata;
    t_vec3               v_rdata;
    t_vec3               key_wdata;
    logic                q_le;
    logic                q_ge;
    logic                in_seg;
    logic                scan_end;
    logic [DATA_W-1:0]   seg_d;
    logic [DATA_W-1:0]   seg_len;
    logic                div_start;
    logic                div_busy;
    logic [QUOT_W-1:0]   frac;
    logic                lerp_start;
    logic                lerp_done;
    t_vec3               lerp_res;
    logic                out_load;

    assign in_xfer = i_in_valid && o_in_ready;
    assign key_wr  = in_xfer && (i_req_type == REQ_WRITE)
                     && (32'(i_key_index) < 32'(MAX_KEYS));
    assign key_wdata = '{x: i_key_x, y: i_key_y, z: i_key_z};

    // effective count: zero acts as one, large values saturate
    always_comb begin
        if (r_key_count == '0) begin
            last_idx = '0;
        end else if (32'(r_key_count) > 32'(MAX_KEYS)) begin
            last_idx = KEY_AW'(MAX_KEYS - 1);
        end else begin
            last_idx = KEY_AW'(r_key_count - 1'b1);
        end
    end

    kvls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (key_wr),
        .i_waddr (KEY_AW'(i_key_index)),
        .i_wdata (i_key_time),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    kvls_ram #(
        .WIDTH (VEC_W),
        .DEPTH (MAX_KEYS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (key_wr),
        .i_waddr (KEY_AW'(i_key_index)),
        .i_wdata (key_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    always_comb begin
        q_le     = $signed(r_q) <= $signed(t_rdata);
        q_ge     = $signed(r_q) >= $signed(t_rdata);
        in_seg   = ($signed(r_q) >= $signed(r_left)) && q_le;
        scan_end = (r_seg + 1'b1) == last_idx;
        seg_d    = r_q - r_left;
        seg_len  = t_rdata - r_left;
    end

    kvls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (seg_d),
        .i_divisor  (seg_len),
        .o_busy     (div_busy),
        .o_quot     (frac)
    );

    kvls_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lerp_start),
        .i_a     (r_va),
        .i_b     (r_vb),
        .i_frac  (frac),
        .o_done  (lerp_done),
        .o_res   (lerp_res)
    );

    assign out_load = (r_state == ST_DONE) && (!o_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_req_type == REQ_SAMPLE)) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: n_state = q_le ? ST_KEY : ST_LAST;
            ST_LAST:  n_state = q_ge ? ST_KEY : ST_SCAN;
            ST_SCAN: begin
                if (in_seg) begin
                    n_state = ST_VAL_L;
                end else if (scan_end) begin
                    n_state = ST_KEY;
                end
            end
            ST_VAL_L: n_state = ST_VAL_R;
            ST_VAL_R: n_state = ST_DIV;
            ST_DIV:   n_state = div_busy ? ST_DIV : ST_LERP;
            ST_LERP:  n_state = lerp_done ? ST_DONE : ST_LERP;
            ST_KEY:   n_state = ST_DONE;
            ST_DONE:  n_state = out_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // read addresses and unit starts
    always_comb begin
        t_raddr    = '0;
        v_raddr    = r_seg;
        div_start  = 1'b0;
        lerp_start = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_FIRST: begin
                t_raddr = last_idx;
                v_raddr = '0;
            end
            ST_LAST: begin
                t_raddr = KEY_AW'(1);
                v_raddr = last_idx;
            end
            ST_SCAN: begin
                // read one key ahead while checking the current segment
                t_raddr   = r_seg + KEY_AW'(2);
                v_raddr   = in_seg ? r_seg : last_idx;
                div_start = in_seg;
            end
            ST_VAL_L: begin
                v_raddr = r_seg + 1'b1;
            end
            ST_DIV: begin
                lerp_start = !div_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= KCNT_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_q <= i_query_time;
            end
            ST_FIRST: begin
                r_left <= t_rdata;
                if (q_le) begin
                    r_seg   <= '0;
                    r_clamp <= CLAMP_FIRST;
                end
            end
            ST_LAST: begin
                r_clamp <= CLAMP_LAST;
                r_seg   <= q_ge ? last_idx : '0;
            end
            ST_SCAN: begin
                if (in_seg) begin
                    r_clamp <= CLAMP_NONE;
                end else if (scan_end) begin
                    r_seg <= last_idx;
                end else begin
                    r_left <= t_rdata;
                    r_seg  <= r_seg + 1'b1;
                end
            end
            ST_VAL_L: r_va <= v_rdata;
            ST_VAL_R: r_vb <= v_rdata;
            ST_LERP: begin
                if (lerp_done) begin
                    r_res <= lerp_res;
                end
            end
            ST_KEY:   r_res <= v_rdata;
            default: begin
            end
        endcase
        if (out_load) begin
            o_out_x       <= r_res.x;
            o_out_y       <= r_res.y;
            o_out_z       <= r_res.z;
            o_out_segment <= SEG_W'(r_seg);
            o_out_clamped <= r_clamp;
        end
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_seg < last_idx))
        else $error("segment scan ran past the last key");

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> div_busy)
        else $error("fraction divider did not start");

    a_lerp_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lerp_done |-> (r_state == ST_LERP))
        else $error("lerp finished outside its wait state");

    a_interp_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_clamp == CLAMP_NONE || r_clamp == CLAMP_FIRST
                      || r_clamp == CLAMP_LAST))
        else $error("illegal clamp code on result");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Randomized regression of the keyframe vec3 lerp sampler unit.
// Drives key writes and sample requests over the request channel and
// predicts every sample from a private copy of the key table and key count.
// A scoreboard checks each output transfer in order. The receiver stalls at
// random, and the key count is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
    import kvls_pkg::*;

    localparam int     ITEM_TARGET   = 650;
    localparam int     SETTLE_CYCLES = 120;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam longint T_MAX         = 64'sd2147483647;
    localparam longint T_MIN         = -64'sd2147483648;

    typedef struct {
        logic              req_type;
        logic [IDX_W-1:0]  key_index;
        logic [DATA_W-1:0] key_time;
        logic [DATA_W-1:0] key_x;
        logic [DATA_W-1:0] key_y;
        logic [DATA_W-1:0] key_z;
        logic [DATA_W-1:0] query_time;
    } t_request;

    typedef struct {
        logic [DATA_W-1:0]  x;
        logic [DATA_W-1:0]  y;
        logic [DATA_W-1:0]  z;
        logic [SEG_W-1:0]   segment;
        logic [CLAMP_W-1:0] clamped;
    } t_sample;

    class lerp_scoreboard;
        int unsigned key_count;
        int          store_time [MAX_KEYS];
        int          store_x    [MAX_KEYS];
        int          store_y    [MAX_KEYS];
        int          store_z    [MAX_KEYS];
        t_sample     pending_samples [$];
        int          fail_count;
        int          checked_count;

        function new();
            key_count     = 1;
            fail_count    = 0;
            checked_count = 0;
            foreach (store_time[k]) begin
                store_time[k] = 0;
                store_x[k]    = 0;
                store_y[k]    = 0;
                store_z[k]    = 0;
            end
        endfunction

        function void set_key_count(logic [KCNT_W-1:0] value);
            key_count = 32'(value);
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= 100)
                $display("MISMATCH: %s", msg);
        endtask

        function logic [DATA_W-1:0] blend(int a, int b, longint frac);
            longint span;
            longint acc;
            span = longint'(b) - longint'(a);
            // arithmetic shift floors toward minus infinity
            acc  = longint'(a) + ((span * frac) >>> FRAC_W);
            return acc[DATA_W-1:0];
        endfunction

        function t_sample key_sample(int k, logic [CLAMP_W-1:0] clamp);
            t_sample r;
            r.x       = store_x[k];
            r.y       = store_y[k];
            r.z       = store_z[k];
            r.segment = k[SEG_W-1:0];
            r.clamped = clamp;
            return r;
        endfunction

        function t_sample interpolate_track(logic [DATA_W-1:0] query);
            t_sample           r;
            int                n;
            int                qword;
            longint            q;
            longint            left;
            longint            right;
            longint unsigned   delta;
            longint unsigned   len;
            longint unsigned   frac;
            n = key_count;
            if (n < 1)
                n = 1;
            if (n > MAX_KEYS)
                n = MAX_KEYS;
            qword = query;
            q     = qword;
            if (q <= store_time[0])
                return key_sample(0, CLAMP_FIRST);
            if (q >= store_time[n-1])
                return key_sample(n - 1, CLAMP_LAST);
            for (int i = 0; i + 1 < n; i++) begin
                left  = store_time[i];
                right = store_time[i+1];
                if (q >= left && q <= right) begin
                    delta     = q - left;
                    len       = right - left;
                    frac      = (len == 0) ? 0 : (delta << FRAC_W) / len;
                    r.x       = blend(store_x[i], store_x[i+1], frac);
                    r.y       = blend(store_y[i], store_y[i+1], frac);
                    r.z       = blend(store_z[i], store_z[i+1], frac);
                    r.segment = i[SEG_W-1:0];
                    r.clamped = CLAMP_NONE;
                    return r;
                end
            end
            return key_sample(n - 1, CLAMP_LAST);
        endfunction

        function void take_request(t_request item);
            if (item.req_type == REQ_WRITE) begin
                store_time[item.key_index] = item.key_time;
                store_x[item.key_index]    = item.key_x;
                store_y[item.key_index]    = item.key_y;
                store_z[item.key_index]    = item.key_z;
            end else begin
                pending_samples.push_back(interpolate_track(item.query_time));
            end
        endfunction

        task check_sample(t_sample got);
            t_sample want;
            if (pending_samples.size() == 0) begin
                report($sformatf("unexpected sample x=%h y=%h z=%h seg=%0d",
                                 got.x, got.y, got.z, got.segment));
                return;
            end
            want = pending_samples.pop_front();
            checked_count++;
            if (got.x !== want.x)
                report($sformatf("sample %0d out_x got %h want %h",
                                 checked_count, got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("sample %0d out_y got %h want %h",
                                 checked_count, got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("sample %0d out_z got %h want %h",
                                 checked_count, got.z, want.z));
            if (got.segment !== want.segment)
                report($sformatf("sample %0d out_segment got %0d want %0d",
                                 checked_count, got.segment, want.segment));
            if (got.clamped !== want.clamped)
                report($sformatf("sample %0d out_clamped got %0d want %0d",
                                 checked_count, got.clamped, want.clamped));
        endtask
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [KCNT_W-1:0]  cfg_wdata     = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic               in_req_type   = REQ_WRITE;
    logic [IDX_W-1:0]   in_key_index  = '0;
    logic [DATA_W-1:0]  in_key_time   = '0;
    logic [DATA_W-1:0]  in_key_x      = '0;
    logic [DATA_W-1:0]  in_key_y      = '0;
    logic [DATA_W-1:0]  in_key_z      = '0;
    logic [DATA_W-1:0]  in_query_time = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [DATA_W-1:0]  out_x;
    logic [DATA_W-1:0]  out_y;
    logic [DATA_W-1:0]  out_z;
    logic [SEG_W-1:0]   out_segment;
    logic [CLAMP_W-1:0] out_clamped;

    bit                 burst    = 1'b0;
    bit                 hold_off = 1'b0;
    int                 items_sent = 0;
    lerp_scoreboard     sb;

    keyframe_vec3_lerp_sampler_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (in_req_type),
        .i_key_index   (in_key_index),
        .i_key_time    (in_key_time),
        .i_key_x       (in_key_x),
        .i_key_y       (in_key_y),
        .i_key_z       (in_key_z),
        .i_query_time  (in_query_time),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_x       (out_x),
        .o_out_y       (out_y),
        .o_out_z       (out_z),
        .o_out_segment (out_segment),
        .o_out_clamped (out_clamped)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        int v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom_range(0, 511) - 256;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Pick a query time near the live track: mostly inside a segment.
    function automatic logic [DATA_W-1:0] pick_query(int n);
        int              roll;
        int              seg;
        int              offset;
        int              w;
        longint          lo;
        longint          hi;
        longint          q;
        longint unsigned span;
        roll = $urandom_range(0, 99);
        if (n >= 2 && roll < 60) begin
            seg = $urandom_range(0, n - 2);
            lo  = sb.store_time[seg];
            hi  = sb.store_time[seg+1];
            if (hi > lo) begin
                span = hi - lo + 1;
                q    = lo + longint'({$urandom, $urandom} % span);
            end else begin
                q = lo;
            end
        end else if (roll < 70) begin
            q = sb.store_time[$urandom_range(0, n - 1)];
        end else if (roll < 80) begin
            offset = $urandom_range(0, 4);
            offset = offset - 2;
            q = ($urandom_range(0, 1) ? sb.store_time[0] : sb.store_time[n-1]);
            q = q + offset;
        end else if (roll < 90) begin
            w = $urandom;
            q = w;
        end else begin
            q = roll[0] ? T_MAX : T_MIN;
        end
        if (q > T_MAX)
            q = T_MAX;
        if (q < T_MIN)
            q = T_MIN;
        return q[DATA_W-1:0];
    endfunction

    // Offer one request and hold it until the transfer.
    task automatic push_item(t_request item);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_req_type   <= item.req_type;
        in_key_index  <= item.key_index;
        in_key_time   <= item.key_time;
        in_key_x      <= item.key_x;
        in_key_y      <= item.key_y;
        in_key_z      <= item.key_z;
        in_query_time <= item.query_time;
        do @(posedge clk); while (!in_ready);
        sb.take_request(item);
        items_sent++;
    endtask

    task automatic push_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] t,
                              logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                              logic [DATA_W-1:0] z);
        t_request item;
        item.req_type   = REQ_WRITE;
        item.key_index  = idx;
        item.key_time   = t;
        item.key_x      = x;
        item.key_y      = y;
        item.key_z      = z;
        item.query_time = $urandom;
        push_item(item);
    endtask

    task automatic push_sample(logic [DATA_W-1:0] q);
        t_request item;
        item.req_type   = REQ_SAMPLE;
        item.key_index  = IDX_W'($urandom);
        item.key_time   = $urandom;
        item.key_x      = $urandom;
        item.key_y      = $urandom;
        item.key_z      = $urandom;
        item.query_time = q;
        push_item(item);
    endtask

    task automatic push_stray_write();
        push_write(IDX_W'($urandom), $urandom, rand_word(), rand_word(),
                   rand_word());
    endtask

    // Drain the unit, then write the key count.
    task automatic set_key_count(logic [KCNT_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_key_count(value);
        cfg_we <= 1'b0;
    endtask

    // Load keys 0..n-1 with a fresh track shape.
    task automatic load_track(int n);
        int              style;
        int              w;
        longint          t;
        longint          step;
        longint unsigned step_cap;
        style = $urandom_range(0, 9);
        w     = $urandom;
        if (style <= 4) begin
            t        = T_MIN + $urandom_range(0, 65536);
            step_cap = 64'd4294967295 / n;
        end else if (style <= 7) begin
            t        = w >>> 1;
            step_cap = 0;
        end else begin
            t        = w >>> 2;
            step_cap = 64'd1 << 20;
        end
        for (int k = 0; k < n; k++) begin
            if (style == 9) begin
                w = $urandom;
                t = w;
            end
            push_write(k[IDX_W-1:0], t[DATA_W-1:0], rand_word(), rand_word(),
                       rand_word());
            if (style >= 5 && style <= 7)
                step = longint'($urandom_range(0, 2)) << 15;  // equal times come often
            else
                step = longint'({$urandom, $urandom} % (step_cap + 1));
            t = t + step;
            if (t > T_MAX)
                t = T_MAX;
        end
    endtask

    always @(posedge clk) begin
        t_sample got;
        if (rst_n && out_valid && out_ready) begin
            got.x       = out_x;
            got.y       = out_y;
            got.z       = out_z;
            got.segment = out_segment;
            got.clamped = out_clamped;
            sb.check_sample(got);
        end
    end

    // Receiver: random stalls, bursts of steady ready, one long hold-off.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end else if (burst) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int roll;
        int count_sel;
        int n_use;
        int reps;
        int waited;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme keys: min and max times, a zero-length middle segment,
        // full-scale value swings, and the all-ones index.
        push_write(6'd0,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_write(6'd1,  32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_write(6'd2,  32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678);
        push_write(6'd3,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hEDCB_A987);
        push_write(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // single key from reset count
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        set_key_count(7'd4);
        push_sample(32'h8000_0000);
        push_sample(32'h8000_0001);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_8000);
        push_sample(32'h0001_0000);  // right end of the first segment
        push_sample(32'h0001_0001);
        push_sample(32'h7FFF_FFFE);
        push_sample(32'h7FFF_FFFF);
        // zero count acts as one key
        set_key_count(7'd0);
        push_sample(32'h0000_0000);
        set_key_count(7'd2);
        push_sample(32'h0000_0000);
        push_sample(32'h7FFF_FFFF);

        // Fill the whole table so any later count reads written keys only.
        load_track(MAX_KEYS);
        set_key_count(7'd64);
        repeat (12) push_sample(pick_query(MAX_KEYS));
        set_key_count(7'd127);
        load_track(8);
        hold_off = 1'b1;
        repeat (16) push_sample(pick_query(MAX_KEYS));

        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                count_sel = $urandom_range(2, 6);
            else if (roll < 62)
                count_sel = $urandom_range(7, 20);
            else if (roll < 70)
                count_sel = 1;
            else if (roll < 76)
                count_sel = 0;
            else if (roll < 83)
                count_sel = 64;
            else if (roll < 90)
                count_sel = $urandom_range(65, 127);
            else
                count_sel = $urandom_range(21, 63);
            burst = ($urandom_range(0, 5) == 0);
            set_key_count(count_sel[KCNT_W-1:0]);
            n_use = (count_sel < 1) ? 1 : (count_sel > MAX_KEYS) ? MAX_KEYS : count_sel;
            if (n_use <= 16 || $urandom_range(0, 2) == 0)
                load_track(n_use);
            reps = (n_use > 20) ? $urandom_range(6, 12) : $urandom_range(8, 24);
            repeat (reps) begin
                // an occasional stray write breaks the track order
                if ($urandom_range(0, 11) == 0)
                    push_stray_write();
                else
                    push_sample(pick_query(n_use));
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d samples never arrived", sb.pending()));
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* keyframe_vec3_lerp_sampler_unit.f */
design/kvls_pkg.sv
design/kvls_ram.sv
design/kvls_div.sv
design/kvls_lerp.sv
design/keyframe_vec3_lerp_sampler_unit.sv
tb/sv/testbench.sv
